/* hw/rtl/pfalu_pkg.sv */
`default_nettype none

package pfalu_pkg;

  // Fixed beat field widths.
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned OPERAND_W = 30;
  localparam int unsigned RESULT_W  = 30;

  // Default prime modulus.
  localparam int unsigned MODULUS_DEF = 32'd1000000007;

  // Operation codes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

endpackage

`default_nettype wire

/* hw/rtl/pfalu_if.sv */
`default_nettype none

// Request channel: opcode and two operands per beat.
interface pfalu_in_if import pfalu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [OPERAND_W-1:0] operand_a;
  logic [OPERAND_W-1:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input opcode, input operand_a, input operand_b,
                  output ready);
endinterface

// Response channel: one residue per beat.
interface pfalu_out_if import pfalu_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pfalu_modmul.sv */
`default_nettype none

// Four-stage Barrett modular multiplier with a valid bit and a sideband
// that travel alongside the data. All stages advance together on en_i.
module pfalu_modmul import pfalu_pkg::*; #(
  parameter int unsigned MODULUS = MODULUS_DEF,
  parameter int unsigned SIDE_W  = 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            valid_i,
  input  logic [$clog2(MODULUS)-1:0]      x_i,
  input  logic [$clog2(MODULUS)-1:0]      y_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [$clog2(MODULUS)-1:0]      z_o,
  output logic [SIDE_W-1:0]               side_o
);

  localparam int unsigned K = $clog2(MODULUS);
  // Barrett constant floor(2^(2K) / M), fits in K+1 bits since M > 2^(K-1).
  localparam logic [K:0]   MU    = (K+1)'((64'd1 << (2*K)) / 64'(MODULUS));
  localparam logic [K+1:0] MOD1  = (K+2)'(MODULUS);
  localparam logic [K+1:0] MOD2  = (K+2)'(64'(MODULUS) << 1);

  logic                v1_q, v2_q, v3_q, v4_q;
  logic [SIDE_W-1:0]   side1_q, side2_q, side3_q, side4_q;
  logic [2*K-1:0]      p1_d, p1_q;
  logic [2*K+1:0]      t2;
  logic [K:0]          q2_d, q2_q;
  logic [K+1:0]        plo2_q;
  logic [K+1:0]        qm3;
  logic [K+1:0]        r3_d, r3_q;
  logic [K-1:0]        z4_d, z4_q;

  // Stage 1: full product.
  assign p1_d = (2*K)'(x_i) * (2*K)'(y_i);

  // Stage 2: quotient estimate from the top bits of the product.
  assign t2   = (2*K+2)'(p1_q[2*K-1:K-1]) * (2*K+2)'(MU);
  assign q2_d = t2[2*K+1:K+1];

  // Stage 3: remainder estimate, below three times the modulus.
  assign qm3  = (K+2)'(q2_q) * MOD1;
  assign r3_d = plo2_q - qm3;

  // Stage 4: one corrective subtraction of twice the modulus or of the modulus, if it fits.
  always_comb begin
    priority if (r3_q >= MOD2) begin
      z4_d = K'(r3_q - MOD2);
    end else if (r3_q >= MOD1) begin
      z4_d = K'(r3_q - MOD1);
    end else begin
      z4_d = K'(r3_q);
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Data and sideband registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= p1_d;
      side1_q <= side_i;
      q2_q    <= q2_d;
      plo2_q  <= p1_q[K+1:0];
      side2_q <= side1_q;
      r3_q    <= r3_d;
      side3_q <= side2_q;
      z4_q    <= z4_d;
      side4_q <= side3_q;
    end
  end

  assign valid_o = v4_q;
  assign z_o     = z4_q;
  assign side_o  = side4_q;

`ifndef SYNTHESIS
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (64'(r3_q) < 64'(3) * 64'(MODULUS)))
    else $error("Barrett remainder estimate out of range");
  a_out_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> (64'(z4_q) < 64'(MODULUS)))
    else $error("modular product not reduced");
  a_valid_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && v3_q) |=> v4_q)
    else $error("valid bit lost between stages");
`endif

endmodule

`default_nettype wire

/* hw/rtl/prime_field_modular_alu.sv */
// Throughput: one beat per cycle while the skid entry is empty; the exponent
// chain is fully unrolled with one four-stage Barrett multiplier per exponent
// bit for the accumulator and one for squaring on every bit but the last.
// Reset clears all valid bits and the output/skid entries; the pipeline is empty.
`default_nettype none

module prime_field_modular_alu import pfalu_pkg::*; #(
  parameter int unsigned MODULUS = MODULUS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  pfalu_in_if.sink     req_i,
  pfalu_out_if.source  rsp_o
);

  localparam int unsigned K = $clog2(MODULUS);
  localparam logic [K-1:0]         EXPO  = K'(MODULUS - 2);
  localparam logic [K:0]           MODK1 = (K+1)'(MODULUS);
  localparam logic [OPERAND_W-1:0] IN_MU =
    OPERAND_W'((64'd1 << OPERAND_W) / 64'(MODULUS));

  typedef struct packed {
    op_e          op;
    logic [K-1:0] a;
    logic [K-1:0] b;
  } side_t;

  localparam int unsigned SIDE_W = $bits(side_t);

  logic en;
  logic va_q, vb_q, vc_q, vd_q;
  op_e  opa_q, opb_q, opc_q, opd_q;

  logic [OPERAND_W-1:0]   raw_a_q [2];
  logic [OPERAND_W-1:0]   raw_b_q [2];
  logic [2*OPERAND_W-1:0] qprod   [2];
  logic [OPERAND_W-1:0]   qb_d    [2];
  logic [OPERAND_W-1:0]   qb_q    [2];
  logic [K:0]             rc_d    [2];
  logic [K:0]             rc_q    [2];
  logic [K-1:0]           red_d   [2];
  logic [K-1:0]           red_q   [2];

  side_t                  side_d;
  logic [K:0]             chain_v;
  logic [K-1:0]           chain_acc  [K+1];
  logic [K-1:0]           chain_base [K];
  logic [SIDE_W-1:0]      chain_side [K+1];
  side_t                  chain_fs;

  logic                   fin_v;
  logic [K-1:0]           fin_z;
  logic [SIDE_W-1:0]      fin_side;
  side_t                  fs;
  logic [K:0]             sum, diff;
  logic [K-1:0]           res_d;

  logic                   push, pop;
  logic                   o_v_d, o_v_q, s_v_d, s_v_q;
  logic [K-1:0]           o_d_d, o_d_q, s_d_d, s_d_q;
  logic [31:0]            o_wide;

  // The whole pipeline advances unless the skid entry is occupied.
  assign en          = !s_v_q;
  assign req_i.ready = en;

  // Front end: reduce both operands modulo M (quotient, remainder, correction).
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qprod[l] = (2*OPERAND_W)'(raw_a_q[l]) * (2*OPERAND_W)'(IN_MU);
      qb_d[l]  = qprod[l][2*OPERAND_W-1:OPERAND_W];
      rc_d[l]  = (K+1)'(raw_b_q[l]) - ((K+1)'(qb_q[l]) * MODK1);
      red_d[l] = (rc_q[l] >= MODK1) ? K'(rc_q[l] - MODK1) : K'(rc_q[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= req_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opa_q      <= op_e'(req_i.opcode);
      raw_a_q[0] <= req_i.operand_a;
      raw_a_q[1] <= req_i.operand_b;
      opb_q      <= opa_q;
      opc_q      <= opb_q;
      opd_q      <= opc_q;
      for (int l = 0; l < 2; l++) begin
        qb_q[l]    <= qb_d[l];
        raw_b_q[l] <= raw_a_q[l];
        rc_q[l]    <= rc_d[l];
        red_q[l]   <= red_d[l];
      end
    end
  end

  // Exponent chain: right-to-left square-and-multiply over the bits of M-2.
  assign side_d.op     = opd_q;
  assign side_d.a      = red_q[0];
  assign side_d.b      = red_q[1];
  assign chain_v[0]    = vd_q;
  assign chain_acc[0]  = K'(1);
  assign chain_base[0] = red_q[1];
  assign chain_side[0] = side_d;

  for (genvar i = 0; i < K; i++) begin : g_step
    pfalu_modmul #(
      .MODULUS (MODULUS),
      .SIDE_W  (SIDE_W)
    ) u_acc (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_v[i]),
      .x_i     (chain_acc[i]),
      .y_i     (EXPO[i] ? chain_base[i] : K'(1)),
      .side_i  (chain_side[i]),
      .valid_o (chain_v[i+1]),
      .z_o     (chain_acc[i+1]),
      .side_o  (chain_side[i+1])
    );

    if (i < K - 1) begin : g_sq
      pfalu_modmul #(
        .MODULUS (MODULUS),
        .SIDE_W  (1)
      ) u_sq (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (chain_v[i]),
        .x_i     (chain_base[i]),
        .y_i     (chain_base[i]),
        .side_i  (1'b0),
        .valid_o (),
        .z_o     (chain_base[i+1]),
        .side_o  ()
      );
    end
  end

  // Final multiply: a times b, or a times the inverse of b.
  assign chain_fs = side_t'(chain_side[K]);

  pfalu_modmul #(
    .MODULUS (MODULUS),
    .SIDE_W  (SIDE_W)
  ) u_final (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (chain_v[K]),
    .x_i     (chain_fs.a),
    .y_i     ((chain_fs.op == OP_MUL) ? chain_fs.b : chain_acc[K]),
    .side_i  (chain_side[K]),
    .valid_o (fin_v),
    .z_o     (fin_z),
    .side_o  (fin_side)
  );

  // Add and subtract are resolved at the end from the carried residues.
  assign fs = side_t'(fin_side);

  always_comb begin
    sum  = (K+1)'(fs.a) + (K+1)'(fs.b);
    if (sum >= MODK1) begin
      sum = sum - MODK1;
    end
    if (fs.a >= fs.b) begin
      diff = (K+1)'(fs.a) - (K+1)'(fs.b);
    end else begin
      diff = (K+1)'(fs.a) + MODK1 - (K+1)'(fs.b);
    end
    unique case (fs.op)
      OP_ADD:         res_d = K'(sum);
      OP_SUB:         res_d = K'(diff);
      OP_MUL, OP_DIV: res_d = fin_z;
      default:        res_d = fin_z;
    endcase
  end

  // Output register plus one skid entry.
  assign push = en && fin_v;
  assign pop  = o_v_q && rsp_o.ready;

  always_comb begin
    o_v_d = o_v_q;
    o_d_d = o_d_q;
    s_v_d = s_v_q;
    s_d_d = s_d_q;
    if (pop) begin
      if (s_v_q) begin
        o_d_d = s_d_q;
        s_v_d = 1'b0;
      end else begin
        o_v_d = push;
        o_d_d = res_d;
      end
    end else if (push) begin
      if (o_v_q) begin
        s_v_d = 1'b1;
        s_d_d = res_d;
      end else begin
        o_v_d = 1'b1;
        o_d_d = res_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
      s_v_q <= 1'b0;
    end else begin
      o_v_q <= o_v_d;
      s_v_q <= s_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    o_d_q <= o_d_d;
    s_d_q <= s_d_d;
  end

  assign o_wide       = 32'(o_d_q);
  assign rsp_o.valid  = o_v_q;
  assign rsp_o.result = o_wide[RESULT_W-1:0];

`ifndef SYNTHESIS
  a_skid_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_v_q |-> o_v_q)
    else $error("skid entry occupied while output register is empty");
  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_v_q |-> (64'(o_d_q) < 64'(MODULUS)))
    else $error("result not reduced");
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> va_q)
    else $error("accepted beat did not enter the pipeline");
  a_drain_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> o_v_q)
    else $error("finished beat did not reach the output register");
`endif

endmodule

`default_nettype wire
